FILE: sv/nonwhite_bounding_box_assert.svh
// Assertion macros shared by the checker of the bounding box block.
`ifndef NONWHITE_BOUNDING_BOX_ASSERT_SVH
`define NONWHITE_BOUNDING_BOX_ASSERT_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define NBB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define NBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// The expression holds at every clock edge out of reset.
`define NBB_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`endif

FILE: sv/nbb_pkg.sv
// Package with types, widths and constants of the bounding box block.
package nbb_pkg;

  // Field widths of items and registers.
  localparam int PIX_W   = 8;
  localparam int SCAN_W  = 13;
  localparam int WID_W   = 13;
  localparam int BPP_W   = 6;
  localparam int TOP_W   = 13;
  localparam int BOT_W   = 14;
  localparam int PX_W    = 15;

  // Configuration port.
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 4;

  // Defaults for the top level parameters.
  localparam int MAX_SCAN_BYTES_DEF = 4096;
  localparam int MAX_ROWS_DEF       = 8192;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // A white byte, and the shift that turns bytes into bits.
  localparam logic [PIX_W-1:0] WHITE_BYTE = 8'hFF;
  localparam int BYTE_SHIFT = 3;

  // Register reset values.
  localparam logic [SCAN_W-1:0] SCAN_RESET = 13'd4096;
  localparam logic [WID_W-1:0]  WID_RESET  = 13'd4096;
  localparam logic [BPP_W-1:0]  BPP_RESET  = 6'd8;

  // Register indexes, taken from the word address.
  localparam logic [1:0] REG_SCAN_BYTES     = 2'd0;
  localparam logic [1:0] REG_WIDTH_BYTES    = 2'd1;
  localparam logic [1:0] REG_BITS_PER_PIXEL = 2'd2;

  // Register contents as seen by the datapath.
  typedef struct packed {
    logic [SCAN_W-1:0] scan_bytes;
    logic [WID_W-1:0]  width_bytes;
    logic [BPP_W-1:0]  bits_per_pixel;
  } cfg_t;

endpackage

FILE: sv/nbb_in_if.sv
// Input channel: one raw frame byte per item.
interface nbb_in_if import nbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_byte;
  logic             last_byte;

  modport source (output valid, output pixel_byte, output last_byte, input ready);
  modport sink   (input valid, input pixel_byte, input last_byte, output ready);
endinterface

FILE: sv/nbb_out_if.sv
// Output channel: one bounding box per item.
interface nbb_out_if import nbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             blank;
  logic [TOP_W-1:0] top_row;
  logic [BOT_W-1:0] bottom_row;
  logic [PX_W-1:0]  left_px;
  logic [PX_W-1:0]  right_px;

  modport source (output valid, output blank, output top_row, output bottom_row,
                  output left_px, output right_px, input ready);
  modport sink   (input valid, input blank, input top_row, input bottom_row,
                  input left_px, input right_px, output ready);
endinterface

FILE: sv/nonwhite_bounding_box.sv
// Top level of the foreground bounding box block.
//
//   channel  dir  handshake       payload
//   pix_i    in   valid/ready     pixel_byte, last_byte
//   box_o    out  valid/ready     blank, top_row, bottom_row, left_px, right_px
//   apb      in   psel/penable    paddr, pwdata, prdata (pready always high)
//
// The front takes one byte per cycle while the queue has room; white and padding
// bytes end there. In its run state the back takes one non-white byte per cycle
// into its min/max update. A non-blank frame end holds the back while the serial
// divider converts the left and then the right column and until the output is free;
// a blank frame end waits only for the output. The queue of QUEUE_DEPTH entries
// absorbs items meanwhile; once it is full pix_i.ready drops, white bytes included.
// After reset the block is ready at once; a stalled output holds its result.
module nonwhite_bounding_box import nbb_pkg::*; #(
  parameter int MAX_SCAN_BYTES = MAX_SCAN_BYTES_DEF,
  parameter int MAX_ROWS       = MAX_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  nbb_in_if.sink            pix_i,
  nbb_out_if.source         box_o
);

  localparam int COL_W   = (MAX_SCAN_BYTES > 1) ? $clog2(MAX_SCAN_BYTES) : 1;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ENTRY_W = ROW_W + COL_W + 2;

  cfg_t               cfg;
  logic               push, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0] push_data, pop_data;

  nbb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nbb_front #(
    .MAX_SCAN_BYTES (MAX_SCAN_BYTES),
    .MAX_ROWS       (MAX_ROWS),
    .COL_W          (COL_W),
    .ROW_W          (ROW_W),
    .ENTRY_W        (ENTRY_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .pix_i        (pix_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  nbb_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_data_i  (push_data),
    .wr_ready_o (push_ready),
    .rd_valid_o (pop_valid),
    .rd_data_o  (pop_data),
    .rd_ready_i (pop_ready)
  );

  nbb_back #(
    .COL_W   (COL_W),
    .ROW_W   (ROW_W),
    .ENTRY_W (ENTRY_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .box_o       (box_o)
  );

endmodule

FILE: sv/nbb_regs.sv
// Configuration registers behind an APB-style port.
module nbb_regs import nbb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [SCAN_W-1:0] scan_q;
  logic [WID_W-1:0]  wid_q;
  logic [BPP_W-1:0]  bpp_q;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes; addresses past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= SCAN_RESET;
      wid_q  <= WID_RESET;
      bpp_q  <= BPP_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SCAN_BYTES:     scan_q <= pwdata[SCAN_W-1:0];
        REG_WIDTH_BYTES:    wid_q  <= pwdata[WID_W-1:0];
        REG_BITS_PER_PIXEL: bpp_q  <= pwdata[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    unique case (reg_idx)
      REG_SCAN_BYTES:     prdata = APB_DW'(scan_q);
      REG_WIDTH_BYTES:    prdata = APB_DW'(wid_q);
      REG_BITS_PER_PIXEL: prdata = APB_DW'(bpp_q);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.scan_bytes     = scan_q;
  assign cfg_o.width_bytes    = wid_q;
  assign cfg_o.bits_per_pixel = bpp_q;

endmodule

FILE: sv/nbb_front.sv
// Front: takes bytes, tracks the scan position and queues non-white bytes
// within the line width, and frame ends.
module nbb_front import nbb_pkg::*; #(
  parameter int MAX_SCAN_BYTES = MAX_SCAN_BYTES_DEF,
  parameter int MAX_ROWS       = MAX_ROWS_DEF,
  parameter int COL_W          = 12,
  parameter int ROW_W          = 13,
  parameter int ENTRY_W        = ROW_W + COL_W + 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  nbb_in_if.sink             pix_i,
  output logic               push_o,
  output logic [ENTRY_W-1:0] push_data_o,
  input  logic               push_ready_i
);

  // Wide enough for the largest scan length, the register range and col+1.
  localparam int CMP_W = (COL_W >= SCAN_W) ? COL_W + 1 : SCAN_W + 1;

  typedef struct packed {
    logic             last;
    logic             hit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } entry_t;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CMP_W-1:0] scan_ext, wid_ext, scan_eff, wid_eff, col_ext;
  logic             accept, hit, line_end;
  entry_t           entry;

  // Effective scan length and image width in bytes of a line.
  always_comb begin
    scan_ext = CMP_W'(cfg_i.scan_bytes);
    wid_ext  = CMP_W'(cfg_i.width_bytes);
    if (scan_ext == '0) begin
      scan_eff = CMP_W'(1);
    end else if (scan_ext > CMP_W'(MAX_SCAN_BYTES)) begin
      scan_eff = CMP_W'(MAX_SCAN_BYTES);
    end else begin
      scan_eff = scan_ext;
    end
    wid_eff = (wid_ext > scan_eff) ? scan_eff : wid_ext;
  end

  // Classify the byte at the current position.
  assign col_ext  = CMP_W'(col_q);
  assign hit      = (col_ext < wid_eff) && (pix_i.pixel_byte != WHITE_BYTE);
  assign line_end = (col_ext + CMP_W'(1)) >= scan_eff;
  assign accept   = pix_i.valid && push_ready_i;

  assign pix_i.ready = push_ready_i;

  // Only non-white bytes and frame ends reach the back.
  assign entry.last  = pix_i.last_byte;
  assign entry.hit   = hit;
  assign entry.row   = row_q;
  assign entry.col   = col_q;
  assign push_o      = accept && (hit || pix_i.last_byte);
  assign push_data_o = entry;

  // Position of the next byte.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (pix_i.last_byte) begin
        col_d = '0;
        row_d = '0;
      end else if (line_end) begin
        col_d = '0;
        row_d = (row_q == ROW_W'(MAX_ROWS - 1)) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: sv/nbb_fifo.sv
// Short queue between the front and the back.
module nbb_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              wr_ready_o,
  output logic              rd_valid_o,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              rd_ready_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/nbb_div.sv
// Serial restoring divider: one quotient bit per cycle.
module nbb_div import nbb_pkg::*; #(
  parameter int DIV_W = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [BPP_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] quo_q;
  logic [BPP_W-1:0] rem_q, dvs_q;
  logic [BPP_W:0]   trial;
  logic             fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= fits ? BPP_W'(trial - {1'b0, dvs_q}) : trial[BPP_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], fits};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: sv/nbb_back.sv
// Back: keeps the running box, and at a non-blank frame end converts the
// columns to pixels; it holds each frame's result for the output channel.
module nbb_back import nbb_pkg::*; #(
  parameter int COL_W   = 12,
  parameter int ROW_W   = 13,
  parameter int ENTRY_W = ROW_W + COL_W + 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               pop_valid_i,
  input  logic [ENTRY_W-1:0] pop_data_i,
  output logic               pop_ready_o,
  nbb_out_if.source          box_o
);

  localparam int DIV_W = COL_W + BYTE_SHIFT;

  typedef struct packed {
    logic             last;
    logic             hit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } entry_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_L_GO,
    ST_L_WAIT,
    ST_R_GO,
    ST_R_WAIT,
    ST_HOLD
  } state_e;

  state_e           state_q;
  entry_t           ent;
  logic             seen_q, nx_seen;
  logic [ROW_W-1:0] minr_q, maxr_q, nx_minr, nx_maxr;
  logic [COL_W-1:0] minc_q, maxc_q, nx_minc, nx_maxc;
  logic [ROW_W:0]   row_after;
  logic             res_blank_q;
  logic [TOP_W-1:0] res_top_q;
  logic [BOT_W-1:0] res_bot_q;
  logic [COL_W-1:0] lcol_q, rcol_q;
  logic [PX_W-1:0]  left_q, right_q;
  logic             out_vld_q;
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_quot;
  logic [BPP_W-1:0] div_divisor;

  assign ent         = entry_t'(pop_data_i);
  assign pop_ready_o = (state_q == ST_RUN);

  // Running box after the popped entry.
  always_comb begin
    nx_seen = seen_q;
    nx_minr = minr_q;
    nx_maxr = maxr_q;
    nx_minc = minc_q;
    nx_maxc = maxc_q;
    if (ent.hit) begin
      if (!seen_q) begin
        nx_seen = 1'b1;
        nx_minr = ent.row;
        nx_maxr = ent.row;
        nx_minc = ent.col;
        nx_maxc = ent.col;
      end else begin
        if (ent.row < minr_q) nx_minr = ent.row;
        if (ent.row > maxr_q) nx_maxr = ent.row;
        if (ent.col < minc_q) nx_minc = ent.col;
        if (ent.col > maxc_q) nx_maxc = ent.col;
      end
    end
  end

  assign row_after = {1'b0, nx_maxr} + (ROW_W + 1)'(1);

  // Column to pixel conversion: col*8 divided by the pixel depth.
  assign div_start    = (state_q == ST_L_GO) || (state_q == ST_R_GO);
  assign div_dividend = (state_q == ST_R_GO) ? {rcol_q, {BYTE_SHIFT{1'b0}}}
                                             : {lcol_q, {BYTE_SHIFT{1'b0}}};
  assign div_divisor  = (cfg_i.bits_per_pixel == '0) ? BPP_W'(1) : cfg_i.bits_per_pixel;

  nbb_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Sequencer, running box and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      seen_q      <= 1'b0;
      minr_q      <= '0;
      maxr_q      <= '0;
      minc_q      <= '0;
      maxc_q      <= '0;
      res_blank_q <= 1'b0;
      res_top_q   <= '0;
      res_bot_q   <= '0;
      lcol_q      <= '0;
      rcol_q      <= '0;
      left_q      <= '0;
      right_q     <= '0;
      out_vld_q   <= 1'b0;
      box_o.blank      <= 1'b0;
      box_o.top_row    <= '0;
      box_o.bottom_row <= '0;
      box_o.left_px    <= '0;
      box_o.right_px   <= '0;
    end else begin
      if (box_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_RUN: begin
          if (pop_valid_i) begin
            if (ent.last) begin
              // Frame end: latch the box and start over.
              res_blank_q <= !nx_seen;
              res_top_q   <= nx_seen ? TOP_W'(nx_minr) : '0;
              res_bot_q   <= nx_seen ? BOT_W'(row_after) : '0;
              lcol_q      <= nx_minc;
              rcol_q      <= nx_maxc;
              left_q      <= '0;
              right_q     <= '0;
              seen_q      <= 1'b0;
              minr_q      <= '0;
              maxr_q      <= '0;
              minc_q      <= '0;
              maxc_q      <= '0;
              state_q     <= nx_seen ? ST_L_GO : ST_HOLD;
            end else begin
              seen_q <= nx_seen;
              minr_q <= nx_minr;
              maxr_q <= nx_maxr;
              minc_q <= nx_minc;
              maxc_q <= nx_maxc;
            end
          end
        end
        ST_L_GO:   state_q <= ST_L_WAIT;
        ST_L_WAIT: begin
          if (div_done) begin
            left_q  <= PX_W'(div_quot);
            state_q <= ST_R_GO;
          end
        end
        ST_R_GO:   state_q <= ST_R_WAIT;
        ST_R_WAIT: begin
          if (div_done) begin
            right_q <= PX_W'(div_quot);
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // Hand the result over once the output register is free.
          if (!out_vld_q || box_o.ready) begin
            out_vld_q        <= 1'b1;
            box_o.blank      <= res_blank_q;
            box_o.top_row    <= res_top_q;
            box_o.bottom_row <= res_bot_q;
            box_o.left_px    <= left_q;
            box_o.right_px   <= right_q;
            state_q          <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  assign box_o.valid = out_vld_q;

endmodule

FILE: sv/nbb_checker.sv
// Port-level checker for the bounding box block, bound to the top level.
`include "nonwhite_bounding_box_assert.svh"

module nbb_checker import nbb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             in_last_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             blank_i,
  input logic [TOP_W-1:0] top_row_i,
  input logic [BOT_W-1:0] bottom_row_i,
  input logic [PX_W-1:0]  left_px_i,
  input logic [PX_W-1:0]  right_px_i
);

  localparam int PEND_MAX = QUEUE_DEPTH + 2;
  localparam int PEND_W   = $clog2(PEND_MAX + 2);
  localparam int BOX_W    = TOP_W + BOT_W + 2 * PX_W;

  logic              last_acc, out_acc, out_wait;
  logic [PEND_W-1:0] pend_q;
  logic [BOX_W-1:0]  coords;
  logic [BOX_W:0]    box_bits;

  assign last_acc = in_valid_i && in_ready_i && in_last_i;
  assign out_acc  = out_valid_i && out_ready_i;
  assign out_wait = out_valid_i && !out_ready_i;

  // The box coordinates, and the whole result with the blank flag.
  assign coords   = {top_row_i, bottom_row_i, left_px_i, right_px_i};
  assign box_bits = {blank_i, coords};

  // Frames accepted whose box has not been delivered yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (last_acc && !out_acc) begin
      pend_q <= pend_q + PEND_W'(1);
    end else if (out_acc && !last_acc) begin
      pend_q <= pend_q - PEND_W'(1);
    end
  end

  `NBB_ASSERT_IMPL(a_no_spurious_box, clk_i, rst_ni, out_acc, pend_q != '0)
  `NBB_ASSERT_ALWAYS(a_pending_bounded, clk_i, rst_ni, pend_q <= PEND_W'(PEND_MAX))
  `NBB_ASSERT_IMPL(a_blank_is_empty, clk_i, rst_ni, out_valid_i && blank_i, coords == '0)
  `NBB_ASSERT_NEXT(a_box_held, clk_i, rst_ni, out_wait, out_valid_i && $stable(box_bits))

endmodule

bind nonwhite_bounding_box nbb_checker u_nbb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (pix_i.valid),
  .in_ready_i   (pix_i.ready),
  .in_last_i    (pix_i.last_byte),
  .out_valid_i  (box_o.valid),
  .out_ready_i  (box_o.ready),
  .blank_i      (box_o.blank),
  .top_row_i    (box_o.top_row),
  .bottom_row_i (box_o.bottom_row),
  .left_px_i    (box_o.left_px),
  .right_px_i   (box_o.right_px)
);
